@@ rtl/ic3x3_pkg.sv @@
// Shared types, constants and arithmetic helpers of the 3x3 image convolution block.
`default_nettype none
package ic3x3_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int COL_BITS    = $clog2(MAX_WIDTH);
  localparam int WID_BITS    = 11;
  localparam int HGT_BITS    = 13;
  localparam int ROW_BITS    = HGT_BITS + 1;
  localparam int PIXEL_BITS  = 8;
  localparam int COEF_BITS   = 16;
  localparam int CH_COUNT    = 3;
  localparam int PIX_W       = CH_COUNT * PIXEL_BITS;
  localparam int KROW_BITS   = 48;
  localparam int PROD_BITS   = PIXEL_BITS + COEF_BITS + 1;
  localparam int ROWSUM_BITS = PROD_BITS + 2;
  localparam int CHSUM_BITS  = ROWSUM_BITS + 2;
  localparam int TOT_BITS    = CHSUM_BITS + 2;
  localparam int SUM_BITS    = 29;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_BITS    = 48;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_K_TOP    = 3'd0,
    CFG_K_MIDDLE = 3'd1,
    CFG_K_BOTTOM = 3'd2,
    CFG_WIDTH    = 3'd3,
    CFG_HEIGHT   = 3'd4,
    CFG_CHANNELS = 3'd5,
    CFG_KEEP     = 3'd6
  } cfg_reg_e;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [2:0] col3_t;
  typedef col3_t [2:0] win_t;
  typedef logic [2:0][KROW_BITS-1:0] kernel_t;
  typedef logic signed [SUM_BITS-1:0] sum_t;

  typedef struct packed {
    logic virt;
    logic at_edge;
    logic regf;
    logic last;
    logic top_clamp;
    logic left_clamp;
  } item_ctl_t;

  typedef struct packed {
    logic res;
    logic last;
  } tag_t;

  function automatic logic signed [PROD_BITS-1:0] mul_tap(
      logic [PIXEL_BITS-1:0] p, logic signed [COEF_BITS-1:0] t);
    logic signed [PROD_BITS-1:0] a;
    logic signed [PROD_BITS-1:0] b;
    a = PROD_BITS'($signed({1'b0, p}));
    b = PROD_BITS'(t);
    return a * b;
  endfunction

  function automatic sum_t sat_sum(logic signed [TOT_BITS-1:0] v);
    logic signed [TOT_BITS-1:0] hi;
    logic signed [TOT_BITS-1:0] lo;
    hi = {{(TOT_BITS-SUM_BITS+1){1'b0}}, {(SUM_BITS-1){1'b1}}};
    lo = ~hi;
    if (v > hi) return {1'b0, {(SUM_BITS-1){1'b1}}};
    else if (v < lo) return {1'b1, {(SUM_BITS-1){1'b0}}};
    else return v[SUM_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/ic3x3_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module ic3x3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/ic3x3_ctrl.sv @@
// Raster position counters and per-transaction output decisions.
`default_nettype none
module ic3x3_ctrl (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            fire,
  input  wire logic                            op,
  input  wire logic [ic3x3_pkg::WID_BITS-1:0]  frame_width,
  input  wire logic [ic3x3_pkg::HGT_BITS-1:0]  frame_height,
  output ic3x3_pkg::item_ctl_t                 ctl,
  output logic                                 ignore,
  output logic      [ic3x3_pkg::COL_BITS-1:0]  rd_col
);
  import ic3x3_pkg::*;

  logic [COL_BITS-1:0] col, col_next;
  logic [ROW_BITS-1:0] row, row_next;
  logic [WID_BITS-1:0] w_eff;
  logic [HGT_BITS-1:0] h_eff;
  logic [ROW_BITS-1:0] h_ext, h1;
  logic                c_wrap, restart;
  logic [COL_BITS-1:0] c1, c_n;
  logic [ROW_BITS-1:0] r1, r_n, orow;
  logic [WID_BITS-1:0] ocol, c_inc;

  always_comb begin
    if (frame_width == '0) w_eff = WID_BITS'(1);
    else if (frame_width > WID_BITS'(MAX_WIDTH)) w_eff = WID_BITS'(MAX_WIDTH);
    else w_eff = frame_width;
    h_eff   = (frame_height == '0) ? HGT_BITS'(1) : frame_height;
    h_ext   = ROW_BITS'(h_eff);
    h1      = h_ext + ROW_BITS'(1);
    c_wrap  = {1'b0, col} >= w_eff;
    c1      = c_wrap ? '0 : col;
    r1      = c_wrap ? row + ROW_BITS'(1) : row;
    restart = (r1 > h1) || (r1 == h1 && c1 != '0);
    c_n     = restart ? '0 : c1;
    r_n     = restart ? '0 : r1;
    ignore  = (r_n < h_ext) && op;
    ctl.virt    = !(r_n < h_ext);
    ctl.at_edge = (c_n == '0) && (r_n >= ROW_BITS'(2));
    ctl.regf    = (c_n != '0) && (r_n != '0);
    orow = ctl.at_edge ? r_n - ROW_BITS'(2) : r_n - ROW_BITS'(1);
    ocol = ctl.at_edge ? w_eff - WID_BITS'(1) : {1'b0, c_n} - WID_BITS'(1);
    ctl.last = (ctl.at_edge || ctl.regf) && (orow == h_ext - ROW_BITS'(1))
               && (ocol == w_eff - WID_BITS'(1));
    ctl.top_clamp  = (orow == '0);
    ctl.left_clamp = (ocol == '0);
    rd_col = c_n;
    c_inc  = {1'b0, c_n} + WID_BITS'(1);
    if (ignore) begin
      col_next = c_n;
      row_next = r_n;
    end else if (ctl.last) begin
      col_next = '0;
      row_next = '0;
    end else if (c_inc >= w_eff) begin
      col_next = '0;
      row_next = r_n + ROW_BITS'(1);
    end else begin
      col_next = c_inc[COL_BITS-1:0];
      row_next = r_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (fire) begin
      col <= col_next;
      row <= row_next;
    end
  end

`ifndef SYNTHESIS
  a_edge_excl: assert property (@(posedge clk) disable iff (rst)
    fire |-> !(ctl.at_edge && ctl.regf))
    else $error("edge and regular output selected together");
  a_last_restart: assert property (@(posedge clk) disable iff (rst)
    fire && !ignore && ctl.last |=> col == '0 && row == '0)
    else $error("frame did not restart after its last output");
  a_ignore_real_row: assert property (@(posedge clk) disable iff (rst)
    ignore |-> !ctl.virt)
    else $error("flush ignored inside the virtual tail row");
`endif

endmodule
`default_nettype wire

@@ rtl/ic3x3_window.sv @@
// Line store, 3x3 window and border selection of the neighborhood.
`default_nettype none
module ic3x3_window (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           en,
  input  wire logic                           fire,
  input  wire logic                           ignore,
  input  wire ic3x3_pkg::item_ctl_t           ctl,
  input  wire logic [ic3x3_pkg::COL_BITS-1:0] rd_col,
  input  wire ic3x3_pkg::pix_t                pix,
  output ic3x3_pkg::tag_t                     s2_tag,
  output ic3x3_pkg::win_t                     s2_win
);
  import ic3x3_pkg::*;

  logic                s1_valid;
  item_ctl_t           s1_ctl;
  logic [COL_BITS-1:0] s1_col;
  pix_t                s1_pix;
  logic                fwd_hit;
  logic [2*PIX_W-1:0]  fwd_data;
  logic [2*PIX_W-1:0]  ram_q, eff, wdata;
  logic                we;
  pix_t                upper, lower, pv;
  col3_t               ncol;
  win_t                win, sel;

  ic3x3_ram #(.WIDTH(2*PIX_W), .DEPTH(MAX_WIDTH)) u_lines (
    .clk  (clk),
    .we   (we),
    .waddr(s1_col),
    .wdata(wdata),
    .re   (fire),
    .raddr(rd_col),
    .rdata(ram_q)
  );

  always_comb begin
    eff   = fwd_hit ? fwd_data : ram_q;
    upper = eff[2*PIX_W-1:PIX_W];
    lower = eff[PIX_W-1:0];
    pv    = s1_ctl.virt ? lower : s1_pix;
    wdata = {lower, pv};
    we    = s1_valid && en;
    ncol[0] = upper;
    ncol[1] = lower;
    ncol[2] = pv;
    sel[0] = s1_ctl.left_clamp ? win[2] : win[1];
    sel[1] = win[2];
    sel[2] = s1_ctl.at_edge ? win[2] : ncol;
    for (int c = 0; c < 3; c++) begin
      if (s1_ctl.top_clamp) sel[c][0] = sel[c][1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_tag   <= '0;
      fwd_hit  <= 1'b0;
      win      <= '0;
    end else if (en) begin
      s1_valid   <= fire && !ignore;
      s2_tag.res <= s1_valid && (s1_ctl.at_edge || s1_ctl.regf);
      s2_tag.last <= s1_ctl.last;
      if (fire) begin
        fwd_hit <= s1_valid && (rd_col == s1_col);
      end
      if (s1_valid) begin
        win[0] <= win[1];
        win[1] <= win[2];
        win[2] <= ncol;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_ctl   <= ctl;
      s1_col   <= rd_col;
      s1_pix   <= pix;
      fwd_data <= wdata;
    end
    if (en) begin
      s2_win <= sel;
    end
  end

endmodule
`default_nettype wire

@@ rtl/ic3x3_mac.sv @@
// Tap multiplies, row sums, channel combining and saturation.
`default_nettype none
module ic3x3_mac (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire ic3x3_pkg::tag_t       s2_tag,
  input  wire ic3x3_pkg::win_t       s2_win,
  input  wire ic3x3_pkg::kernel_t    kernel,
  input  wire logic [1:0]            channel_count,
  input  wire logic                  keep_channels,
  output logic                       out_valid,
  output ic3x3_pkg::sum_t            sum_ch0,
  output ic3x3_pkg::sum_t            sum_ch1,
  output ic3x3_pkg::sum_t            sum_ch2,
  output logic                       frame_end
);
  import ic3x3_pkg::*;

  tag_t                          s3_tag;
  logic signed [ROWSUM_BITS-1:0] rsum [CH_COUNT][3];
  logic signed [ROWSUM_BITS-1:0] rsum_next [CH_COUNT][3];
  logic signed [CHSUM_BITS-1:0]  chsum [CH_COUNT];
  logic signed [TOT_BITS-1:0]    tot;
  logic [1:0]                    nch;

  always_comb begin
    for (int ch = 0; ch < CH_COUNT; ch++) begin
      for (int r = 0; r < 3; r++) begin
        rsum_next[ch][r] = '0;
        for (int c = 0; c < 3; c++) begin
          rsum_next[ch][r] = rsum_next[ch][r] + ROWSUM_BITS'(mul_tap(
            s2_win[c][r][ch*PIXEL_BITS +: PIXEL_BITS],
            $signed(kernel[r][c*COEF_BITS +: COEF_BITS])));
        end
      end
    end
  end

  always_comb begin
    nch = (channel_count == 2'd0) ? 2'd1 : channel_count;
    tot = '0;
    for (int ch = 0; ch < CH_COUNT; ch++) begin
      chsum[ch] = CHSUM_BITS'(rsum[ch][0]) + CHSUM_BITS'(rsum[ch][1])
                  + CHSUM_BITS'(rsum[ch][2]);
      if (2'(ch) >= nch) chsum[ch] = '0;
      tot = tot + TOT_BITS'(chsum[ch]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_tag    <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      s3_tag    <= s2_tag;
      out_valid <= s3_tag.res;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsum      <= rsum_next;
      frame_end <= s3_tag.last;
      if (keep_channels) begin
        sum_ch0 <= sat_sum(TOT_BITS'(chsum[0]));
        sum_ch1 <= sat_sum(TOT_BITS'(chsum[1]));
        sum_ch2 <= sat_sum(TOT_BITS'(chsum[2]));
      end else begin
        sum_ch0 <= sat_sum(tot);
        sum_ch1 <= '0;
        sum_ch2 <= '0;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/image_convolution_3x3_top.sv @@
// Top level of the streaming 3x3 image convolution with configuration registers.
//
//   channel | signals                                   | role
//   in      | in_valid, in_ready, op, pixel_ch0..2      | pixel or flush transaction
//   out     | out_valid, out_ready, sum_ch0..2, frame_end | one windowed sum result
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register write
//
// One input transaction is accepted per cycle while no output stall holds in_ready low;
// a result is registered through the line-store read, window, multiply and sum
// stages in turn. The line store is one RAM with one read and one write per cycle.
// An output stall freezes every stage and lowers in_ready in the same cycle.
// Reset restores the register defaults and restarts the frame; the line store
// needs no clearing pass.
`default_nettype none
module image_convolution_3x3_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                op,
  input  wire logic [ic3x3_pkg::PIXEL_BITS-1:0]    pixel_ch0,
  input  wire logic [ic3x3_pkg::PIXEL_BITS-1:0]    pixel_ch1,
  input  wire logic [ic3x3_pkg::PIXEL_BITS-1:0]    pixel_ch2,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output ic3x3_pkg::sum_t                          sum_ch0,
  output ic3x3_pkg::sum_t                          sum_ch1,
  output ic3x3_pkg::sum_t                          sum_ch2,
  output logic                                     frame_end,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [ic3x3_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [ic3x3_pkg::CFG_BITS-1:0]      cfg_data
);
  import ic3x3_pkg::*;

  kernel_t             kernel;
  logic [WID_BITS-1:0] frame_width;
  logic [HGT_BITS-1:0] frame_height;
  logic [1:0]          channel_count;
  logic                keep_channels;
  logic                en, fire, ignore;
  item_ctl_t           ctl;
  logic [COL_BITS-1:0] rd_col;
  tag_t                s2_tag;
  win_t                s2_win;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign fire      = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel[0]     <= '0;
      kernel[1]     <= KROW_BITS'(4096);
      kernel[2]     <= '0;
      frame_width   <= WID_BITS'(640);
      frame_height  <= HGT_BITS'(480);
      channel_count <= 2'd3;
      keep_channels <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_reg_e'(cfg_index))
        CFG_K_TOP:    kernel[0]     <= cfg_data[KROW_BITS-1:0];
        CFG_K_MIDDLE: kernel[1]     <= cfg_data[KROW_BITS-1:0];
        CFG_K_BOTTOM: kernel[2]     <= cfg_data[KROW_BITS-1:0];
        CFG_WIDTH:    frame_width   <= cfg_data[WID_BITS-1:0];
        CFG_HEIGHT:   frame_height  <= cfg_data[HGT_BITS-1:0];
        CFG_CHANNELS: channel_count <= cfg_data[1:0];
        CFG_KEEP:     keep_channels <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ic3x3_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .op          (op),
    .frame_width (frame_width),
    .frame_height(frame_height),
    .ctl         (ctl),
    .ignore      (ignore),
    .rd_col      (rd_col)
  );

  ic3x3_window u_window (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .fire  (fire),
    .ignore(ignore),
    .ctl   (ctl),
    .rd_col(rd_col),
    .pix   ({pixel_ch2, pixel_ch1, pixel_ch0}),
    .s2_tag(s2_tag),
    .s2_win(s2_win)
  );

  ic3x3_mac u_mac (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .s2_tag       (s2_tag),
    .s2_win       (s2_win),
    .kernel       (kernel),
    .channel_count(channel_count),
    .keep_channels(keep_channels),
    .out_valid    (out_valid),
    .sum_ch0      (sum_ch0),
    .sum_ch1      (sum_ch1),
    .sum_ch2      (sum_ch2),
    .frame_end    (frame_end)
  );

`ifndef SYNTHESIS
  a_sum_mode_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !keep_channels |-> sum_ch1 == '0 && sum_ch2 == '0)
    else $error("sum mode result carries nonzero upper channels");
  a_one_channel: assert property (@(posedge clk) disable iff (rst)
    out_valid && keep_channels && (channel_count == 2'd1 || channel_count == 2'd0)
    |-> sum_ch1 == '0 && sum_ch2 == '0)
    else $error("unused channel produced a nonzero sum");
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without an output stall");
`endif

endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the streaming 3x3 image convolution top level.
`timescale 1ns / 1ps
module testbench;
  import ic3x3_pkg::*;

  typedef struct {
    bit pause;
    bit op;
    logic [7:0] c0, c1, c2;
  } stream_item_t;

  typedef struct {
    sum_t s0, s1, s2;
    logic fe;
  } conv_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic op = 1'b0;
  logic [7:0] pixel_ch0 = '0, pixel_ch1 = '0, pixel_ch2 = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  sum_t sum_ch0, sum_ch1, sum_ch2;
  logic frame_end;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_BITS-1:0] cfg_data = '0;

  stream_item_t pending_items[$];
  conv_result_t expected_sums[$];
  int errors = 0;
  int checked = 0;
  int accepted = 0;
  int frames = 0;
  int send_idle = 0;
  int recv_idle = 0;

  logic [47:0] kern_row[3];
  int reg_width, reg_height, reg_channels;
  bit reg_keep;
  logic [23:0] upper_line[MAX_WIDTH];
  logic [23:0] lower_line[MAX_WIDTH];
  logic [23:0] win_px[3][3];
  int in_col, in_row, out_col, out_row;

  image_convolution_3x3_top dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic longint kern_tap(int r, int c);
    return longint'($signed(kern_row[r][c*16 +: 16]));
  endfunction

  function automatic sum_t clamp_sum(longint v);
    if (v > 268435455) return sum_t'(268435455);
    if (v < -268435456) return sum_t'(-268435456);
    return sum_t'(v);
  endfunction

  function automatic conv_result_t window_sum(logic [23:0] wv[3][3], int cols[3], bit top_clamp);
    conv_result_t res;
    longint acc[3];
    int rows[3];
    int nch;
    nch = reg_channels == 0 ? 1 : reg_channels;
    rows[0] = top_clamp ? 1 : 0;
    rows[1] = 1;
    rows[2] = 2;
    for (int ch = 0; ch < 3; ch++) begin
      acc[ch] = 0;
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++)
          acc[ch] += longint'(wv[rows[r]][cols[c]][ch*8 +: 8]) * kern_tap(r, c);
      if (ch >= nch) acc[ch] = 0;
    end
    if (reg_keep) begin
      res.s0 = clamp_sum(acc[0]);
      res.s1 = clamp_sum(acc[1]);
      res.s2 = clamp_sum(acc[2]);
    end else begin
      res.s0 = clamp_sum(acc[0] + acc[1] + acc[2]);
      res.s1 = '0;
      res.s2 = '0;
    end
    return res;
  endfunction

  function automatic int eff_width();
    if (reg_width == 0) return 1;
    if (reg_width > MAX_WIDTH) return MAX_WIDTH;
    return reg_width;
  endfunction

  function automatic int eff_height();
    return reg_height == 0 ? 1 : reg_height;
  endfunction

  function automatic void predict_convolution(bit is_flush, logic [23:0] px_in);
    int w, h, ic, ir;
    logic [23:0] px;
    logic [23:0] pre[3][3];
    int cols[3];
    bit have, last;
    conv_result_t res;
    w = eff_width();
    h = eff_height();
    have = 0;
    last = 0;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (in_row > h + 1 || (in_row == h + 1 && in_col != 0)) begin
      in_row = 0; in_col = 0; out_row = 0; out_col = 0;
    end
    ic = in_col;
    ir = in_row;
    if (ir < h) begin
      if (is_flush) return;
      px = px_in;
    end else begin
      px = lower_line[ic];
    end
    pre = win_px;
    if (ic == 0 && ir >= 2) begin
      out_row = ir - 2;
      out_col = w - 1;
      cols[0] = out_col == 0 ? 2 : 1;
      cols[1] = 2;
      cols[2] = 2;
      res = window_sum(pre, cols, out_row == 0);
      have = 1;
    end
    for (int r = 0; r < 3; r++) begin
      win_px[r][0] = win_px[r][1];
      win_px[r][1] = win_px[r][2];
    end
    win_px[0][2] = upper_line[ic];
    win_px[1][2] = lower_line[ic];
    win_px[2][2] = px;
    upper_line[ic] = lower_line[ic];
    lower_line[ic] = px;
    if (ic >= 1 && ir >= 1) begin
      out_row = ir - 1;
      out_col = ic - 1;
      cols[0] = out_col == 0 ? 1 : 0;
      cols[1] = 1;
      cols[2] = 2;
      res = window_sum(win_px, cols, out_row == 0);
      have = 1;
    end
    if (have) begin
      last = out_row == h - 1 && out_col == w - 1;
      res.fe = last;
      expected_sums.push_back(res);
    end
    if (last) begin
      in_row = 0; in_col = 0; out_row = 0; out_col = 0;
    end else begin
      in_col = ic + 1;
      if (in_col >= w) begin
        in_col = 0;
        in_row = ir + 1;
      end
    end
  endfunction

  function automatic void apply_register(cfg_reg_e idx, logic [47:0] value);
    case (idx)
      CFG_K_TOP:    kern_row[0] = value;
      CFG_K_MIDDLE: kern_row[1] = value;
      CFG_K_BOTTOM: kern_row[2] = value;
      CFG_WIDTH:    reg_width = value[10:0];
      CFG_HEIGHT:   reg_height = value[12:0];
      CFG_CHANNELS: reg_channels = value[1:0];
      CFG_KEEP:     reg_keep = value[0];
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_convolution(op, {pixel_ch2, pixel_ch1, pixel_ch0});
        accepted++;
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() != 0 && pending_items[0].pause) begin
          if (expected_sums.size() == 0) void'(pending_items.pop_front());
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0 && $urandom_range(99) >= send_idle) begin
          stream_item_t it;
          it = pending_items.pop_front();
          in_valid <= 1'b1;
          op <= it.op;
          pixel_ch0 <= it.c0;
          pixel_ch1 <= it.c1;
          pixel_ch2 <= it.c2;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= $urandom_range(99) >= recv_idle;
      if (out_valid && out_ready) begin
        if (expected_sums.size() == 0) begin
          errors++;
          $display("%0t: unexpected result sum_ch0=%0d frame_end=%0b", $time, sum_ch0,
                   frame_end);
        end else begin
          conv_result_t e;
          e = expected_sums.pop_front();
          checked++;
          if (sum_ch0 !== e.s0) begin
            errors++;
            $display("%0t: sum_ch0 expected %0d actual %0d", $time, e.s0, sum_ch0);
          end
          if (sum_ch1 !== e.s1) begin
            errors++;
            $display("%0t: sum_ch1 expected %0d actual %0d", $time, e.s1, sum_ch1);
          end
          if (sum_ch2 !== e.s2) begin
            errors++;
            $display("%0t: sum_ch2 expected %0d actual %0d", $time, e.s2, sum_ch2);
          end
          if (frame_end !== e.fe) begin
            errors++;
            $display("%0t: frame_end expected %0b actual %0b", $time, e.fe, frame_end);
          end
        end
      end
    end
  end

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || expected_sums.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(cfg_reg_e idx, logic [47:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_register(idx, value);
  endtask

  task automatic configure(logic [47:0] k0, logic [47:0] k1, logic [47:0] k2, int w, int h,
                           int ch, bit keep);
    wait_idle();
    write_register(CFG_K_TOP, k0);
    write_register(CFG_K_MIDDLE, k1);
    write_register(CFG_K_BOTTOM, k2);
    write_register(CFG_WIDTH, 48'(w));
    write_register(CFG_HEIGHT, 48'(h));
    write_register(CFG_CHANNELS, 48'(ch));
    write_register(CFG_KEEP, 48'(keep));
  endtask

  function automatic logic [7:0] pick_sample(int style);
    if (style == 1) return 8'h00;
    if (style == 2) return 8'hFF;
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic push_item(bit is_flush, int style);
    stream_item_t it;
    it.pause = 0;
    it.op = is_flush;
    it.c0 = pick_sample(style);
    it.c1 = pick_sample(style);
    it.c2 = pick_sample(style);
    pending_items.push_back(it);
  endtask

  task automatic push_frame(int style, bit noise, bit hold);
    int w, h;
    stream_item_t it;
    w = eff_width();
    h = eff_height();
    for (int i = 0; i < w * h; i++) begin
      if (noise && $urandom_range(99) < 4) push_item(1, 0);
      if (hold && i == (w * h) / 2) begin
        it.pause = 1;
        pending_items.push_back(it);
      end
      push_item(0, style);
    end
    for (int i = 0; i <= w; i++) push_item(noise ? $urandom_range(3) == 0 : 0, style);
    if (noise && $urandom_range(1)) push_item(1, 0);
    frames++;
  endtask

  function automatic logic [47:0] random_kernel_row();
    logic [47:0] row;
    if ($urandom_range(3) == 0) return {16'($urandom), 32'($urandom)};
    for (int c = 0; c < 3; c++)
      case ($urandom_range(4))
        0: row[c*16 +: 16] = 16'h7FFF;
        1: row[c*16 +: 16] = 16'h8000;
        2: row[c*16 +: 16] = 16'($urandom);
        default: row[c*16 +: 16] = 16'($urandom_range(8192) - 4096);
      endcase
    return row;
  endfunction

  task automatic random_phase(bit hold);
    int w, h;
    w = $urandom_range(9) == 0 ? $urandom_range(16, 40) : $urandom_range(0, 8);
    h = $urandom_range(0, 6);
    configure(random_kernel_row(), random_kernel_row(), random_kernel_row(), w, h,
              $urandom_range(3), $urandom_range(1));
    repeat ($urandom_range(1, 2)) push_frame(0, 1, hold);
  endtask

  task automatic set_idle(int mode);
    case (mode)
      0: begin send_idle = 32; recv_idle = 48; end
      1: begin send_idle = 48; recv_idle = 32; end
      default: begin send_idle = 0; recv_idle = 0; end
    endcase
  endtask

  initial begin
    kern_row[0] = 48'd0;
    kern_row[1] = 48'd4096;
    kern_row[2] = 48'd0;
    reg_width = 640;
    reg_height = 480;
    reg_channels = 3;
    reg_keep = 1;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      upper_line[i] = '0;
      lower_line[i] = '0;
    end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        win_px[r][c] = '0;
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    set_idle(0);
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    configure(48'd0, 48'd4096, 48'd0, 3, 3, 3, 1);
    push_frame(2, 0, 0);
    push_frame(1, 0, 0);
    configure({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, 1, 1, 3, 0);
    push_frame(2, 0, 0);
    configure({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, 2, 2, 3, 1);
    push_frame(2, 0, 0);
    configure(random_kernel_row(), random_kernel_row(), random_kernel_row(), 0, 0, 0, 1);
    push_frame(0, 0, 0);
    push_item(1, 0);
    configure(random_kernel_row(), random_kernel_row(), random_kernel_row(), 3, 2, 2, 0);
    push_frame(0, 1, 0);

    // The width shrinks after one and a half rows, so the second row ends early.
    configure(random_kernel_row(), random_kernel_row(), random_kernel_row(), 4, 4, 3, 1);
    repeat (6) push_item(0, 0);
    wait_idle();
    write_register(CFG_WIDTH, 48'd2);
    repeat (4) push_item(0, 0);
    repeat (4) push_item(1, 0);
    // The height drops below the current row, so the frame starts over.
    configure(random_kernel_row(), random_kernel_row(), random_kernel_row(), 3, 5, 3, 0);
    repeat (9) push_item(0, 0);
    wait_idle();
    write_register(CFG_HEIGHT, 48'd1);
    push_frame(0, 1, 0);

    for (int p = 0; p < 18; p++) begin
      set_idle(p / 6);
      random_phase(p == 4 || p == 14);
      if (p == 9) begin
        configure(random_kernel_row(), random_kernel_row(), random_kernel_row(), 40, 1, 1, 0);
        push_frame(0, 1, 0);
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (expected_sums.size() != 0) errors++;
    $display("Covered %0d frames over %0d accepted transactions; %0d results checked.",
             frames, accepted, checked);
    $display("Settings included widths 0 to 40, heights 0 to 6, all channel modes.");
    if (errors == 0) begin
      $display("image_convolution_3x3_top regression: pass");
    end else begin
      $display("image_convolution_3x3_top regression: fail");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("Timed out with %0d results outstanding.", expected_sums.size());
    $display("image_convolution_3x3_top regression: fail");
    $finish;
  end

endmodule

@@ image_convolution_3x3_top.f @@
rtl/ic3x3_pkg.sv
rtl/ic3x3_ram.sv
rtl/ic3x3_ctrl.sv
rtl/ic3x3_window.sv
rtl/ic3x3_mac.sv
rtl/image_convolution_3x3_top.sv
tb/sv/testbench.sv
